/* src/cni_pkg.sv */
// ----------------------------------------------------------------------------
// Collocation Newmark integrator package
// Shared types, codes, constants and the microcode table of the sequencer.
// ----------------------------------------------------------------------------
package cni_pkg;

    localparam int NUM_DOFS_DEF = 256;
    localparam int DATA_W       = 64;
    localparam int CFG_IDX_W    = 3;
    localparam int PC_W         = 6;

    localparam logic [63:0] FX_ONE  = 64'h0000_0001_0000_0000;
    localparam logic [63:0] FX_HALF = 64'h0000_0000_8000_0000;

    localparam logic [CFG_IDX_W-1:0] CFG_THETA  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BETA   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAMMA  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_REDUCT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DT     = 3'd4;

    localparam logic [PC_W-1:0] PC_NEW_STEP = 6'd0;
    localparam logic [PC_W-1:0] PC_UPDATE   = 6'd19;
    localparam logic [PC_W-1:0] PC_COMMIT   = 6'd25;

    typedef enum logic [2:0] {
        CMD_LOAD     = 3'd0,
        CMD_NEW_STEP = 3'd1,
        CMD_UPDATE   = 3'd2,
        CMD_COMMIT   = 3'd3,
        CMD_REVERT   = 3'd4
    } t_cmd;

    typedef enum logic [1:0] {
        STS_OK       = 2'd0,
        STS_THETA    = 2'd1,
        STS_DT       = 2'd2,
        STS_SAT      = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        OP_ADD,
        OP_SUB,
        OP_MUL,
        OP_DIV
    } t_op;

    typedef enum logic [4:0] {
        S_ZERO, S_ONE, S_HALF, S_TH, S_DT, S_SDT, S_B, S_G, S_RED, S_DIN,
        S_WD, S_WV, S_WA, S_CD, S_CV, S_CA, S_C2, S_C3,
        S_T0, S_T1, S_T2, S_T3, S_T4, S_T5, S_T6, S_T7
    } t_src;

    typedef enum logic [3:0] {
        D_T0, D_T1, D_T2, D_T3, D_T4, D_T5, D_T6, D_T7,
        D_WD, D_WV, D_WA, D_C2, D_C3
    } t_dst;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_FETCH,
        ST_ISSUE,
        ST_WAIT,
        ST_WRITE,
        ST_DONE
    } t_state;

    typedef struct packed {
        t_op  op;
        t_src sa;
        t_src sb;
        t_dst dst;
        logic last;
    } t_uop;

    typedef struct packed {
        logic              start;
        t_op               op;
        logic [DATA_W-1:0] a;
        logic [DATA_W-1:0] b;
    } t_alu_req;

    typedef struct packed {
        logic              done;
        logic [DATA_W-1:0] res;
        logic              sat;
    } t_alu_rsp;

    function automatic t_uop uop_rom(logic [PC_W-1:0] pc);
        t_uop u;
        u = '{OP_ADD, S_ZERO, S_ZERO, D_T0, 1'b1};
        unique case (pc)
            // new step
            6'd0:  u = '{OP_MUL, S_TH,   S_DT,   D_T0, 1'b0};
            6'd1:  u = '{OP_MUL, S_B,    S_T0,   D_T1, 1'b0};
            6'd2:  u = '{OP_DIV, S_ONE,  S_T1,   D_T2, 1'b0};
            6'd3:  u = '{OP_MUL, S_G,    S_T2,   D_C2, 1'b0};
            6'd4:  u = '{OP_DIV, S_T2,   S_T0,   D_C3, 1'b0};
            6'd5:  u = '{OP_DIV, S_G,    S_B,    D_T3, 1'b0};
            6'd6:  u = '{OP_SUB, S_ONE,  S_T3,   D_T4, 1'b0};
            6'd7:  u = '{OP_MUL, S_HALF, S_T3,   D_T1, 1'b0};
            6'd8:  u = '{OP_SUB, S_ONE,  S_T1,   D_T1, 1'b0};
            6'd9:  u = '{OP_MUL, S_T0,   S_T1,   D_T5, 1'b0};
            6'd10: u = '{OP_SUB, S_ZERO, S_T2,   D_T6, 1'b0};
            6'd11: u = '{OP_DIV, S_HALF, S_B,    D_T1, 1'b0};
            6'd12: u = '{OP_SUB, S_ONE,  S_T1,   D_T7, 1'b0};
            6'd13: u = '{OP_MUL, S_T4,   S_CV,   D_T1, 1'b0};
            6'd14: u = '{OP_MUL, S_T5,   S_CA,   D_T3, 1'b0};
            6'd15: u = '{OP_ADD, S_T1,   S_T3,   D_WV, 1'b0};
            6'd16: u = '{OP_MUL, S_T7,   S_CA,   D_T1, 1'b0};
            6'd17: u = '{OP_MUL, S_T6,   S_CV,   D_T3, 1'b0};
            6'd18: u = '{OP_ADD, S_T1,   S_T3,   D_WA, 1'b1};
            // update
            6'd19: u = '{OP_MUL, S_RED,  S_DIN,  D_T0, 1'b0};
            6'd20: u = '{OP_ADD, S_WD,   S_T0,   D_WD, 1'b0};
            6'd21: u = '{OP_MUL, S_C2,   S_T0,   D_T1, 1'b0};
            6'd22: u = '{OP_ADD, S_WV,   S_T1,   D_WV, 1'b0};
            6'd23: u = '{OP_MUL, S_C3,   S_T0,   D_T1, 1'b0};
            6'd24: u = '{OP_ADD, S_WA,   S_T1,   D_WA, 1'b1};
            // commit
            6'd25: u = '{OP_DIV, S_ONE,  S_TH,   D_T0, 1'b0};
            6'd26: u = '{OP_SUB, S_TH,   S_ONE,  D_T1, 1'b0};
            6'd27: u = '{OP_DIV, S_T1,   S_TH,   D_T1, 1'b0};
            6'd28: u = '{OP_MUL, S_T0,   S_WA,   D_T0, 1'b0};
            6'd29: u = '{OP_MUL, S_T1,   S_CA,   D_T1, 1'b0};
            6'd30: u = '{OP_ADD, S_T0,   S_T1,   D_WA, 1'b0};
            6'd31: u = '{OP_SUB, S_ONE,  S_G,    D_T0, 1'b0};
            6'd32: u = '{OP_MUL, S_SDT,  S_T0,   D_T0, 1'b0};
            6'd33: u = '{OP_MUL, S_T0,   S_CA,   D_T0, 1'b0};
            6'd34: u = '{OP_ADD, S_CV,   S_T0,   D_T3, 1'b0};
            6'd35: u = '{OP_MUL, S_SDT,  S_G,    D_T0, 1'b0};
            6'd36: u = '{OP_MUL, S_T0,   S_WA,   D_T0, 1'b0};
            6'd37: u = '{OP_ADD, S_T3,   S_T0,   D_WV, 1'b0};
            6'd38: u = '{OP_MUL, S_SDT,  S_SDT,  D_T4, 1'b0};
            6'd39: u = '{OP_MUL, S_CV,   S_SDT,  D_T0, 1'b0};
            6'd40: u = '{OP_ADD, S_CD,   S_T0,   D_T5, 1'b0};
            6'd41: u = '{OP_SUB, S_HALF, S_B,    D_T0, 1'b0};
            6'd42: u = '{OP_MUL, S_T4,   S_T0,   D_T0, 1'b0};
            6'd43: u = '{OP_MUL, S_T0,   S_CA,   D_T0, 1'b0};
            6'd44: u = '{OP_ADD, S_T5,   S_T0,   D_T5, 1'b0};
            6'd45: u = '{OP_MUL, S_T4,   S_B,    D_T0, 1'b0};
            6'd46: u = '{OP_MUL, S_T0,   S_WA,   D_T0, 1'b0};
            6'd47: u = '{OP_ADD, S_T5,   S_T0,   D_WD, 1'b1};
            default: u = '{OP_ADD, S_ZERO, S_ZERO, D_T0, 1'b1};
        endcase
        return u;
    endfunction

endpackage

/* src/cni_if.sv */
// ----------------------------------------------------------------------------
// Collocation Newmark integrator channels
// Request, result and configuration channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface cni_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  cmd;
    logic [7:0]  dof_index;
    logic [63:0] disp_in;
    logic [63:0] vel_in;
    logic [63:0] accel_in;

    modport source (output valid, cmd, dof_index, disp_in, vel_in, accel_in, input ready);
    modport sink   (input valid, cmd, dof_index, disp_in, vel_in, accel_in, output ready);
endinterface

interface cni_rsp_if;
    logic        valid;
    logic        ready;
    logic [7:0]  dof_out;
    logic [63:0] disp_out;
    logic [63:0] vel_out;
    logic [63:0] accel_out;
    logic [1:0]  status;

    modport source (output valid, dof_out, disp_out, vel_out, accel_out, status, input ready);
    modport sink   (input valid, dof_out, disp_out, vel_out, accel_out, status, output ready);
endinterface

interface cni_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [63:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* src/cni_ram.sv */
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module cni_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  logic                             i_clk,
    input  logic                             i_we,
    input  logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                 i_wdata,
    input  logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                 o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

/* src/cni_alu.sv */
// ----------------------------------------------------------------------------
// Collocation Newmark integrator arithmetic unit
// Shared saturating Q31.32 add, subtract, 4-pass multiply and bit-serial divide.
// ----------------------------------------------------------------------------
module cni_alu (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  cni_pkg::t_alu_req i_req,
    output cni_pkg::t_alu_rsp o_rsp
);

    localparam logic [63:0] MIN_VAL = 64'h8000_0000_0000_0000;
    localparam logic [63:0] MAX_VAL = 64'h7FFF_FFFF_FFFF_FFFF;

    logic             r_busy;
    logic             r_done;
    cni_pkg::t_op     r_op;
    logic [6:0]       r_cnt;
    logic [63:0]      r_a;
    logic [63:0]      r_b;
    logic [63:0]      r_res;
    logic             r_sat;
    logic [63:0]      r_pp;
    logic [1:0]       r_ppk;
    logic [127:0]     r_acc;
    logic [64:0]      r_rem;
    logic [63:0]      r_nlo;
    logic [63:0]      r_q;

    logic [63:0]      w_ma;
    logic [63:0]      w_mb;
    logic             w_neg;
    logic [63:0]      w_sum;
    logic [63:0]      w_dif;
    logic [31:0]      w_ma32;
    logic [31:0]      w_mb32;
    logic [127:0]     w_pp_sh;
    logic [127:0]     w_rnd;
    logic [63:0]      w_mmag;
    logic [64:0]      w_rem2;

    function automatic logic [64:0] pack(logic neg, logic [63:0] m);
        logic [64:0] r;
        if (neg) begin
            if (m > MIN_VAL) begin
                r = {1'b1, MIN_VAL};
            end else begin
                r = {1'b0, 64'(~m + 64'd1)};
            end
        end else if (m[63]) begin
            r = {1'b1, MAX_VAL};
        end else begin
            r = {1'b0, m};
        end
        return r;
    endfunction

    assign w_ma  = r_a[63] ? 64'(~r_a + 64'd1) : r_a;
    assign w_mb  = r_b[63] ? 64'(~r_b + 64'd1) : r_b;
    assign w_neg = r_a[63] ^ r_b[63];
    assign w_sum = r_a + r_b;
    assign w_dif = r_a - r_b;
    assign w_ma32 = r_cnt[1] ? w_ma[63:32] : w_ma[31:0];
    assign w_mb32 = r_cnt[0] ? w_mb[63:32] : w_mb[31:0];
    assign w_rnd  = r_acc + 128'h8000_0000;
    assign w_mmag = (w_rnd[127:96] != 32'd0) ? '1 : w_rnd[95:32];
    assign w_rem2 = {r_rem[63:0], r_nlo[63]};

    always_comb begin
        unique case (r_ppk)
            2'd0:    w_pp_sh = 128'(r_pp);
            2'd1:    w_pp_sh = 128'(r_pp) << 32;
            2'd2:    w_pp_sh = 128'(r_pp) << 32;
            default: w_pp_sh = 128'(r_pp) << 64;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_op   <= i_req.op;
                r_a    <= i_req.a;
                r_b    <= i_req.b;
                r_cnt  <= '0;
                r_acc  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 7'd1;
                unique case (r_op)
                    cni_pkg::OP_ADD: begin
                        r_busy <= 1'b0;
                        r_done <= 1'b1;
                        if (r_a[63] == r_b[63] && w_sum[63] != r_a[63]) begin
                            r_res <= r_a[63] ? MIN_VAL : MAX_VAL;
                            r_sat <= 1'b1;
                        end else begin
                            r_res <= w_sum;
                            r_sat <= 1'b0;
                        end
                    end
                    cni_pkg::OP_SUB: begin
                        r_busy <= 1'b0;
                        r_done <= 1'b1;
                        if (r_a[63] != r_b[63] && w_dif[63] != r_a[63]) begin
                            r_res <= r_a[63] ? MIN_VAL : MAX_VAL;
                            r_sat <= 1'b1;
                        end else begin
                            r_res <= w_dif;
                            r_sat <= 1'b0;
                        end
                    end
                    cni_pkg::OP_MUL: begin
                        if (r_cnt < 7'd4) begin
                            r_pp  <= 64'(w_ma32) * 64'(w_mb32);
                            r_ppk <= r_cnt[1:0];
                        end
                        if (r_cnt >= 7'd1 && r_cnt <= 7'd4) begin
                            r_acc <= r_acc + w_pp_sh;
                        end
                        if (r_cnt == 7'd5) begin
                            r_busy <= 1'b0;
                            r_done <= 1'b1;
                            {r_sat, r_res} <= pack(w_neg, w_mmag);
                        end
                    end
                    default: begin
                        if (r_cnt == 7'd0) begin
                            r_rem <= {1'b0, 32'd0, w_ma[63:32]};
                            r_nlo <= {w_ma[31:0], 32'd0};
                            r_q   <= '0;
                            if (w_mb == 64'd0) begin
                                r_busy <= 1'b0;
                                r_done <= 1'b1;
                                if (w_ma == 64'd0) begin
                                    {r_sat, r_res} <= 65'd0;
                                end else begin
                                    r_sat <= 1'b1;
                                    r_res <= r_a[63] ? MIN_VAL : MAX_VAL;
                                end
                            end else if ({32'd0, w_ma[63:32]} >= w_mb) begin
                                r_busy <= 1'b0;
                                r_done <= 1'b1;
                                {r_sat, r_res} <= pack(w_neg, '1);
                            end
                        end else if (r_cnt <= 7'd64) begin
                            r_nlo <= {r_nlo[62:0], 1'b0};
                            if (w_rem2 >= {1'b0, w_mb}) begin
                                r_rem <= w_rem2 - {1'b0, w_mb};
                                r_q   <= {r_q[62:0], 1'b1};
                            end else begin
                                r_rem <= w_rem2;
                                r_q   <= {r_q[62:0], 1'b0};
                            end
                        end else begin
                            r_busy <= 1'b0;
                            r_done <= 1'b1;
                            {r_sat, r_res} <= pack(w_neg, r_q);
                        end
                    end
                endcase
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.res  = r_res;
    assign o_rsp.sat  = r_sat;

endmodule

/* src/collocation_newmark_integrator_core.sv */
// ----------------------------------------------------------------------------
// Collocation Newmark integrator core: per-DOF state in RAM, microcode on one ALU.
// Request path: READ, FETCH, ISSUE/WAIT per microcode step (update, commit, new step),
// WRITE (skipped on unknown command, out-of-range DOF, rejected new step), DONE; some divides end early.
// Throughput: next request accepted in the cycle after the result is registered.
// Reset: synchronous; clears sequencer, reduct, dt, latched dt, coefficients; sets theta 1, beta 1/4, gamma 1/2.
// ----------------------------------------------------------------------------
module collocation_newmark_integrator_core #(
    parameter int NUM_DOFS = cni_pkg::NUM_DOFS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    cni_req_if.sink    i_req,
    cni_rsp_if.source  o_rsp,
    cni_cfg_if.sink    i_cfg
);

    localparam int AW = (NUM_DOFS > 1) ? $clog2(NUM_DOFS) : 1;

    cni_pkg::t_state      r_state;
    cni_pkg::t_state      n_state;
    logic [62:0]          r_theta;
    logic [63:0]          r_beta;
    logic [63:0]          r_gamma;
    logic [63:0]          r_reduct;
    logic [62:0]          r_dt;
    logic [62:0]          r_sdt;
    logic [63:0]          r_c2;
    logic [63:0]          r_c3;
    logic [cni_pkg::PC_W-1:0] r_pc;
    logic [2:0]           r_cmd;
    logic [7:0]           r_dof;
    logic [63:0]          r_din;
    logic [63:0]          r_vin;
    logic [63:0]          r_ain;
    logic [63:0]          r_wd;
    logic [63:0]          r_wv;
    logic [63:0]          r_wa;
    logic [63:0]          r_cd;
    logic [63:0]          r_cv;
    logic [63:0]          r_ca;
    logic [63:0]          r_tmp [8];
    logic                 r_sat;
    cni_pkg::t_status     r_status;
    logic                 r_ovalid;
    logic [7:0]           r_odof;
    logic [63:0]          r_od;
    logic [63:0]          r_ov;
    logic [63:0]          r_oa;
    logic [1:0]           r_osts;

    logic                 w_in_range;
    logic [AW-1:0]        w_addr;
    logic [191:0]         w_trial_rd;
    logic [191:0]         w_comm_rd;
    logic                 w_trial_we;
    logic                 w_comm_we;
    logic                 w_req_ready;
    logic                 w_out_free;
    cni_pkg::t_uop        w_uop;
    cni_pkg::t_alu_req    w_alu_req;
    cni_pkg::t_alu_rsp    w_alu_rsp;

    function automatic logic [63:0] src_val(cni_pkg::t_src s);
        logic [63:0] v;
        unique case (s)
            cni_pkg::S_ZERO: v = '0;
            cni_pkg::S_ONE:  v = cni_pkg::FX_ONE;
            cni_pkg::S_HALF: v = cni_pkg::FX_HALF;
            cni_pkg::S_TH:   v = {1'b0, r_theta};
            cni_pkg::S_DT:   v = {1'b0, r_dt};
            cni_pkg::S_SDT:  v = {1'b0, r_sdt};
            cni_pkg::S_B:    v = r_beta;
            cni_pkg::S_G:    v = r_gamma;
            cni_pkg::S_RED:  v = r_reduct;
            cni_pkg::S_DIN:  v = r_din;
            cni_pkg::S_WD:   v = r_wd;
            cni_pkg::S_WV:   v = r_wv;
            cni_pkg::S_WA:   v = r_wa;
            cni_pkg::S_CD:   v = r_cd;
            cni_pkg::S_CV:   v = r_cv;
            cni_pkg::S_CA:   v = r_ca;
            cni_pkg::S_C2:   v = r_c2;
            cni_pkg::S_C3:   v = r_c3;
            cni_pkg::S_T0:   v = r_tmp[0];
            cni_pkg::S_T1:   v = r_tmp[1];
            cni_pkg::S_T2:   v = r_tmp[2];
            cni_pkg::S_T3:   v = r_tmp[3];
            cni_pkg::S_T4:   v = r_tmp[4];
            cni_pkg::S_T5:   v = r_tmp[5];
            cni_pkg::S_T6:   v = r_tmp[6];
            cni_pkg::S_T7:   v = r_tmp[7];
            default:         v = '0;
        endcase
        return v;
    endfunction

    assign w_in_range = {24'd0, r_dof} < 32'(NUM_DOFS);
    assign w_addr     = AW'(r_dof);
    assign w_uop      = cni_pkg::uop_rom(r_pc);
    assign w_out_free = !r_ovalid || o_rsp.ready;

    cni_ram #(.WIDTH(192), .DEPTH(NUM_DOFS)) u_trial_ram (
        .i_clk   (i_clk),
        .i_we    (w_trial_we),
        .i_waddr (w_addr),
        .i_wdata ({r_wd, r_wv, r_wa}),
        .i_raddr (w_addr),
        .o_rdata (w_trial_rd)
    );

    cni_ram #(.WIDTH(192), .DEPTH(NUM_DOFS)) u_comm_ram (
        .i_clk   (i_clk),
        .i_we    (w_comm_we),
        .i_waddr (w_addr),
        .i_wdata ({r_cd, r_cv, r_ca}),
        .i_raddr (w_addr),
        .o_rdata (w_comm_rd)
    );

    cni_alu u_alu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_alu_req),
        .o_rsp   (w_alu_rsp)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            cni_pkg::ST_IDLE: begin
                if (i_req.valid) begin
                    n_state = cni_pkg::ST_READ;
                end
            end
            cni_pkg::ST_READ: n_state = cni_pkg::ST_FETCH;
            cni_pkg::ST_FETCH: begin
                if (!w_in_range) begin
                    n_state = cni_pkg::ST_DONE;
                end else begin
                    unique case (r_cmd)
                        cni_pkg::CMD_LOAD:   n_state = cni_pkg::ST_WRITE;
                        cni_pkg::CMD_REVERT: n_state = cni_pkg::ST_WRITE;
                        cni_pkg::CMD_UPDATE: n_state = cni_pkg::ST_ISSUE;
                        cni_pkg::CMD_COMMIT: n_state = cni_pkg::ST_ISSUE;
                        cni_pkg::CMD_NEW_STEP: begin
                            if (r_theta == '0 || r_dt == '0) begin
                                n_state = cni_pkg::ST_DONE;
                            end else begin
                                n_state = cni_pkg::ST_ISSUE;
                            end
                        end
                        default: n_state = cni_pkg::ST_DONE;
                    endcase
                end
            end
            cni_pkg::ST_ISSUE: n_state = cni_pkg::ST_WAIT;
            cni_pkg::ST_WAIT: begin
                if (w_alu_rsp.done) begin
                    n_state = w_uop.last ? cni_pkg::ST_WRITE : cni_pkg::ST_ISSUE;
                end
            end
            cni_pkg::ST_WRITE: n_state = cni_pkg::ST_DONE;
            cni_pkg::ST_DONE: begin
                if (w_out_free) begin
                    n_state = cni_pkg::ST_IDLE;
                end
            end
            default: n_state = cni_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        w_req_ready     = (r_state == cni_pkg::ST_IDLE);
        w_trial_we      = (r_state == cni_pkg::ST_WRITE);
        w_comm_we       = (r_state == cni_pkg::ST_WRITE) && (r_cmd == cni_pkg::CMD_NEW_STEP);
        w_alu_req.start = (r_state == cni_pkg::ST_ISSUE);
        w_alu_req.op    = w_uop.op;
        w_alu_req.a     = src_val(w_uop.sa);
        w_alu_req.b     = src_val(w_uop.sb);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= cni_pkg::ST_IDLE;
            r_ovalid <= 1'b0;
            r_theta  <= 63'h1_0000_0000;
            r_beta   <= 64'h4000_0000;
            r_gamma  <= 64'h8000_0000;
            r_reduct <= '0;
            r_dt     <= '0;
            r_sdt    <= '0;
            r_c2     <= '0;
            r_c3     <= '0;
        end else begin
            r_state <= n_state;

            if (i_cfg.valid) begin
                unique case (i_cfg.index)
                    cni_pkg::CFG_THETA:  r_theta  <= i_cfg.data[62:0];
                    cni_pkg::CFG_BETA:   r_beta   <= i_cfg.data;
                    cni_pkg::CFG_GAMMA:  r_gamma  <= i_cfg.data;
                    cni_pkg::CFG_REDUCT: r_reduct <= i_cfg.data;
                    cni_pkg::CFG_DT:     r_dt     <= i_cfg.data[62:0];
                    default: ;
                endcase
            end

            if (r_ovalid && o_rsp.ready && r_state != cni_pkg::ST_DONE) begin
                r_ovalid <= 1'b0;
            end

            unique case (r_state)
                cni_pkg::ST_IDLE: begin
                    if (i_req.valid) begin
                        r_cmd <= i_req.cmd;
                        r_dof <= i_req.dof_index;
                        r_din <= i_req.disp_in;
                        r_vin <= i_req.vel_in;
                        r_ain <= i_req.accel_in;
                    end
                end
                cni_pkg::ST_FETCH: begin
                    r_sat    <= 1'b0;
                    r_status <= cni_pkg::STS_OK;
                    if (!w_in_range) begin
                        {r_wd, r_wv, r_wa} <= '0;
                        {r_cd, r_cv, r_ca} <= w_comm_rd;
                    end else begin
                        unique case (r_cmd)
                            cni_pkg::CMD_LOAD: begin
                                {r_wd, r_wv, r_wa} <= {r_din, r_vin, r_ain};
                                {r_cd, r_cv, r_ca} <= w_comm_rd;
                            end
                            cni_pkg::CMD_REVERT: begin
                                {r_wd, r_wv, r_wa} <= w_comm_rd;
                                {r_cd, r_cv, r_ca} <= w_comm_rd;
                            end
                            cni_pkg::CMD_UPDATE: begin
                                {r_wd, r_wv, r_wa} <= w_trial_rd;
                                {r_cd, r_cv, r_ca} <= w_comm_rd;
                                r_pc <= cni_pkg::PC_UPDATE;
                            end
                            cni_pkg::CMD_COMMIT: begin
                                {r_wd, r_wv, r_wa} <= w_trial_rd;
                                {r_cd, r_cv, r_ca} <= w_comm_rd;
                                r_pc <= cni_pkg::PC_COMMIT;
                            end
                            cni_pkg::CMD_NEW_STEP: begin
                                {r_wd, r_wv, r_wa} <= w_trial_rd;
                                {r_cd, r_cv, r_ca} <= w_trial_rd;
                                r_pc <= cni_pkg::PC_NEW_STEP;
                                if (r_theta == '0) begin
                                    r_status <= cni_pkg::STS_THETA;
                                end else begin
                                    r_sdt <= r_dt;
                                    if (r_dt == '0) begin
                                        r_status <= cni_pkg::STS_DT;
                                    end
                                end
                            end
                            default: begin
                                {r_wd, r_wv, r_wa} <= w_trial_rd;
                                {r_cd, r_cv, r_ca} <= w_comm_rd;
                            end
                        endcase
                    end
                end
                cni_pkg::ST_WAIT: begin
                    if (w_alu_rsp.done) begin
                        r_sat <= r_sat | w_alu_rsp.sat;
                        r_pc  <= r_pc + 1'b1;
                        unique case (w_uop.dst)
                            cni_pkg::D_WD: r_wd <= w_alu_rsp.res;
                            cni_pkg::D_WV: r_wv <= w_alu_rsp.res;
                            cni_pkg::D_WA: r_wa <= w_alu_rsp.res;
                            cni_pkg::D_C2: r_c2 <= w_alu_rsp.res;
                            cni_pkg::D_C3: r_c3 <= w_alu_rsp.res;
                            default: r_tmp[w_uop.dst[2:0]] <= w_alu_rsp.res;
                        endcase
                    end
                end
                cni_pkg::ST_DONE: begin
                    if (w_out_free) begin
                        r_ovalid <= 1'b1;
                        r_odof   <= r_dof;
                        r_od     <= r_wd;
                        r_ov     <= r_wv;
                        r_oa     <= r_wa;
                        if (r_status != cni_pkg::STS_OK) begin
                            r_osts <= r_status;
                        end else if (r_sat) begin
                            r_osts <= cni_pkg::STS_SAT;
                        end else begin
                            r_osts <= cni_pkg::STS_OK;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    assign i_req.ready     = w_req_ready;
    assign i_cfg.ready     = 1'b1;
    assign o_rsp.valid     = r_ovalid;
    assign o_rsp.dof_out   = r_odof;
    assign o_rsp.disp_out  = r_od;
    assign o_rsp.vel_out   = r_ov;
    assign o_rsp.accel_out = r_oa;
    assign o_rsp.status    = r_osts;

endmodule

/* tb/newmark_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Collocation Newmark integrator checker
// Watches the configuration, request and result channels, keeps its own
// per-DOF state and Q31.32 saturating arithmetic, predicts one result per
// accepted request and compares results field by field in order.
// ----------------------------------------------------------------------------
module newmark_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    cni_req_if   req,
    cni_rsp_if   rsp,
    cni_cfg_if   cfg,
    output int   o_fail_count,
    output int   o_pending
);

    localparam logic [63:0] POS_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] NEG_MIN = 64'h8000_0000_0000_0000;
    localparam logic [63:0] MASK63  = 64'h7FFF_FFFF_FFFF_FFFF;

    typedef struct packed {
        logic [7:0]       dof;
        logic [63:0]      disp;
        logic [63:0]      vel;
        logic [63:0]      accel;
        cni_pkg::t_status status;
    } t_result;

    logic [63:0] theta_r, beta_r, gamma_r, reduct_r, dt_r;
    logic [63:0] step_dt, coef_vel, coef_acc;
    logic [63:0] trial_d [256];
    logic [63:0] trial_v [256];
    logic [63:0] trial_a [256];
    logic [63:0] commit_d [256];
    logic [63:0] commit_v [256];
    logic [63:0] commit_a [256];
    bit          sat;
    t_result     result_q[$];
    t_result     want;
    t_result     pred;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    function automatic logic [63:0] mag(logic [63:0] x);
        return x[63] ? (~x + 64'd1) : x;
    endfunction

    function logic [63:0] pack(bit neg, logic [63:0] m);
        if (neg) begin
            if (m > NEG_MIN) begin
                sat = 1'b1;
                m = NEG_MIN;
            end
            return ~m + 64'd1;
        end
        if (m > POS_MAX) begin
            sat = 1'b1;
            m = POS_MAX;
        end
        return m;
    endfunction

    function logic [63:0] q_add(logic [63:0] a, logic [63:0] b);
        logic [63:0] r;
        r = a + b;
        if (a[63] == b[63] && r[63] != a[63]) begin
            sat = 1'b1;
            return a[63] ? NEG_MIN : POS_MAX;
        end
        return r;
    endfunction

    function logic [63:0] q_sub(logic [63:0] a, logic [63:0] b);
        logic [63:0] r;
        r = a - b;
        if (a[63] != b[63] && r[63] != a[63]) begin
            sat = 1'b1;
            return a[63] ? NEG_MIN : POS_MAX;
        end
        return r;
    endfunction

    function logic [63:0] q_mul(logic [63:0] a, logic [63:0] b);
        logic [127:0] p;
        logic [63:0]  m;
        p = {64'd0, mag(a)} * {64'd0, mag(b)} + 128'h8000_0000;
        m = (p[127:96] != 0) ? '1 : p[95:32];
        return pack(a[63] != b[63], m);
    endfunction

    function logic [63:0] q_div(logic [63:0] a, logic [63:0] b);
        logic [63:0]  ma, mb;
        logic [127:0] q;
        ma = mag(a);
        mb = mag(b);
        if (mb == 0) begin
            if (ma == 0) return 64'd0;
            sat = 1'b1;
            return pack(a[63], '1);
        end
        if ({32'd0, ma[63:32]} >= mb) return pack(a[63] != b[63], '1);
        q = {32'd0, ma, 32'd0} / {64'd0, mb};
        return pack(a[63] != b[63], q[63:0]);
    endfunction

    task automatic predict_item(input logic [2:0] cmd, input logic [7:0] k,
                                input logic [63:0] din, vin, ain, output t_result r);
        logic [63:0] td, inv, gb, a1, a2, a3, a4, cv, ca, s;
        logic [63:0] inv_th, f, acc, vel, disp, d2;
        cni_pkg::t_status st;
        st  = cni_pkg::STS_OK;
        sat = 1'b0;
        case (cmd)
            cni_pkg::CMD_LOAD: begin
                trial_d[k] = din;
                trial_v[k] = vin;
                trial_a[k] = ain;
            end
            cni_pkg::CMD_NEW_STEP: begin
                if (theta_r == 0) begin
                    st = cni_pkg::STS_THETA;
                end else begin
                    step_dt = dt_r;
                    if (dt_r == 0) begin
                        st = cni_pkg::STS_DT;
                    end else begin
                        td       = q_mul(theta_r, dt_r);
                        inv      = q_div(cni_pkg::FX_ONE, q_mul(beta_r, td));
                        coef_vel = q_mul(gamma_r, inv);
                        coef_acc = q_div(inv, td);
                        commit_d[k] = trial_d[k];
                        commit_v[k] = trial_v[k];
                        commit_a[k] = trial_a[k];
                        cv = commit_v[k];
                        ca = commit_a[k];
                        gb = q_div(gamma_r, beta_r);
                        a1 = q_sub(cni_pkg::FX_ONE, gb);
                        a2 = q_mul(td, q_sub(cni_pkg::FX_ONE, q_mul(cni_pkg::FX_HALF, gb)));
                        a3 = q_sub(64'd0, inv);
                        a4 = q_sub(cni_pkg::FX_ONE, q_div(cni_pkg::FX_HALF, beta_r));
                        trial_v[k] = q_add(q_mul(a1, cv), q_mul(a2, ca));
                        trial_a[k] = q_add(q_mul(a4, ca), q_mul(a3, cv));
                    end
                end
            end
            cni_pkg::CMD_UPDATE: begin
                s = q_mul(reduct_r, din);
                trial_d[k] = q_add(trial_d[k], s);
                trial_v[k] = q_add(trial_v[k], q_mul(coef_vel, s));
                trial_a[k] = q_add(trial_a[k], q_mul(coef_acc, s));
            end
            cni_pkg::CMD_COMMIT: begin
                cv     = commit_v[k];
                ca     = commit_a[k];
                inv_th = q_div(cni_pkg::FX_ONE, theta_r);
                f      = q_div(q_sub(theta_r, cni_pkg::FX_ONE), theta_r);
                acc    = q_add(q_mul(inv_th, trial_a[k]), q_mul(f, ca));
                vel    = q_add(cv, q_mul(q_mul(step_dt, q_sub(cni_pkg::FX_ONE, gamma_r)), ca));
                vel    = q_add(vel, q_mul(q_mul(step_dt, gamma_r), acc));
                d2     = q_mul(step_dt, step_dt);
                disp   = q_add(commit_d[k], q_mul(cv, step_dt));
                disp   = q_add(disp, q_mul(q_mul(d2, q_sub(cni_pkg::FX_HALF, beta_r)), ca));
                disp   = q_add(disp, q_mul(q_mul(d2, beta_r), acc));
                trial_d[k] = disp;
                trial_v[k] = vel;
                trial_a[k] = acc;
            end
            cni_pkg::CMD_REVERT: begin
                trial_d[k] = commit_d[k];
                trial_v[k] = commit_v[k];
                trial_a[k] = commit_a[k];
            end
            default: begin
            end
        endcase
        if (st == cni_pkg::STS_OK && sat) st = cni_pkg::STS_SAT;
        r = '{k, trial_d[k], trial_v[k], trial_a[k], st};
    endtask

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] exp_v);
        $display("%0t: %s mismatch: got %h, want %h", $realtime, what, got, exp_v);
        o_fail_count++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            theta_r  <= cni_pkg::FX_ONE;
            beta_r   <= 64'h4000_0000;
            gamma_r  <= cni_pkg::FX_HALF;
            reduct_r <= '0;
            dt_r     <= '0;
            step_dt  <= '0;
            coef_vel <= '0;
            coef_acc <= '0;
            result_q.delete();
        end else begin
            if (rsp.valid && rsp.ready) begin
                if (result_q.size() == 0) begin
                    report("unexpected result, dof", 64'(rsp.dof_out), '0);
                end else begin
                    want = result_q.pop_front();
                    if (rsp.dof_out !== want.dof)
                        report("dof", 64'(rsp.dof_out), 64'(want.dof));
                    if (rsp.disp_out !== want.disp) report("disp", rsp.disp_out, want.disp);
                    if (rsp.vel_out !== want.vel) report("vel", rsp.vel_out, want.vel);
                    if (rsp.accel_out !== want.accel)
                        report("accel", rsp.accel_out, want.accel);
                    if (rsp.status !== want.status)
                        report("status", 64'(rsp.status), 64'(want.status));
                end
            end
            if (cfg.valid && cfg.ready) begin
                case (cfg.index)
                    cni_pkg::CFG_THETA:  theta_r  = cfg.data & MASK63;
                    cni_pkg::CFG_BETA:   beta_r   = cfg.data;
                    cni_pkg::CFG_GAMMA:  gamma_r  = cfg.data;
                    cni_pkg::CFG_REDUCT: reduct_r = cfg.data;
                    cni_pkg::CFG_DT:     dt_r     = cfg.data & MASK63;
                    default: begin
                    end
                endcase
            end
            if (req.valid && req.ready) begin
                predict_item(req.cmd, req.dof_index, req.disp_in, req.vel_in, req.accel_in,
                             pred);
                result_q.push_back(pred);
            end
        end
        o_pending = result_q.size();
    end

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Collocation Newmark integrator testbench
// Directed requests for extremes, every command and the special cases, then
// random load/step/update/commit/revert and reserved-command sequences over several
// configurations, with bursty requests and a stalling result receiver.
// ----------------------------------------------------------------------------
module tb_top;

    localparam logic [2:0]  CMD_RSVD_LO = 3'd5;
    localparam logic [2:0]  CMD_RSVD_HI = 3'd7;
    localparam logic [63:0] Q_MAX   = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] Q_MIN   = 64'h8000_0000_0000_0000;
    localparam logic [63:0] Q_QUART = 64'h4000_0000;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    int   item_count;
    int   burst_left;
    int   gap_max;
    int   rx_left;
    int   rx_mode;
    bit   hold_rsp;
    bit   loaded [256];
    bit   stepped [256];
    logic [63:0] cur_theta, cur_dt;

    cni_req_if req_ch ();
    cni_rsp_if rsp_ch ();
    cni_cfg_if cfg_ch ();

    collocation_newmark_integrator_core u_top (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_ch),
        .o_rsp  (rsp_ch),
        .i_cfg  (cfg_ch)
    );

    newmark_checker u_chk (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .req         (req_ch),
        .rsp         (rsp_ch),
        .cfg         (cfg_ch),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    initial begin
        #30_000_000;
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        rsp_ch.ready = 1'b0;
        rx_left = 0;
        rx_mode = 0;
    end

    always @(negedge i_clk) begin
        if (rx_left == 0) begin
            rx_mode = $urandom_range(3);
            rx_left = $urandom_range(512, 64);
        end
        rx_left--;
        case (rx_mode)
            0: rsp_ch.ready <= !hold_rsp;
            1: rsp_ch.ready <= !hold_rsp && $urandom_range(1);
            2: rsp_ch.ready <= !hold_rsp && ($urandom_range(3) == 0);
            default: rsp_ch.ready <= !hold_rsp && (rx_left[4:0] < 5'd6);
        endcase
    end

    // hold results back long enough that the core stalls its request input
    initial begin
        hold_rsp = 1'b0;
        wait (item_count >= 400);
        hold_rsp = 1'b1;
        repeat (3000) @(posedge i_clk);
        hold_rsp = 1'b0;
    end

    function automatic logic [63:0] rand_q();
        logic [63:0] v;
        case ($urandom_range(9))
            0: v = {$urandom, $urandom};
            1: begin
                case ($urandom_range(2))
                    0: v = Q_MAX;
                    1: v = Q_MIN;
                    default: v = '0;
                endcase
            end
            default: begin
                v = {{32{1'b0}}, $urandom};
                v[43:32] = 12'($urandom);
                if ($urandom_range(1)) v = ~v + 64'd1;
            end
        endcase
        return v;
    endfunction

    task automatic write_reg(input logic [2:0] idx, input logic [63:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        do @(posedge i_clk); while (!cfg_ch.ready);
        @(negedge i_clk);
    endtask

    task automatic set_config(input logic [63:0] th, b, g, red, dt);
        write_reg(cni_pkg::CFG_THETA, th);
        write_reg(cni_pkg::CFG_BETA, b);
        write_reg(cni_pkg::CFG_GAMMA, g);
        write_reg(cni_pkg::CFG_REDUCT, red);
        write_reg(cni_pkg::CFG_DT, dt);
        cfg_ch.valid <= 1'b0;
        cur_theta = th & Q_MAX;
        cur_dt    = dt & Q_MAX;
    endtask

    task automatic send_req(input logic [2:0] cmd, input logic [7:0] k,
                            input logic [63:0] d, v, a);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(gap_max);
            if (gap > 0) begin
                req_ch.valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = $urandom_range(12, 1);
        end
        burst_left--;
        req_ch.valid     <= 1'b1;
        req_ch.cmd       <= cmd;
        req_ch.dof_index <= k;
        req_ch.disp_in   <= d;
        req_ch.vel_in    <= v;
        req_ch.accel_in  <= a;
        do @(posedge i_clk); while (!req_ch.ready);
        item_count++;
        if (cmd == cni_pkg::CMD_LOAD) loaded[k] = 1'b1;
        if (cmd == cni_pkg::CMD_NEW_STEP && cur_theta != 0 && cur_dt != 0) stepped[k] = 1'b1;
        @(negedge i_clk);
    endtask

    task automatic drain();
        req_ch.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (400) @(negedge i_clk);
    endtask

    function automatic logic [63:0] pick_reg(input logic [63:0] typical);
        case ($urandom_range(9))
            0: return Q_MAX;
            1: return Q_MIN;
            2: return '0;
            3: return {$urandom, $urandom};
            default: return typical;
        endcase
    endfunction

    task automatic random_item();
        logic [7:0]  k;
        logic [2:0]  cmd;
        int          r;
        k = ($urandom_range(3) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(15));
        r = $urandom_range(99);
        if (!loaded[k] || r < 8) cmd = cni_pkg::CMD_LOAD;
        else if (r < 28) cmd = cni_pkg::CMD_NEW_STEP;
        else if (r < 63) cmd = cni_pkg::CMD_UPDATE;
        else if (r < 78) cmd = stepped[k] ? cni_pkg::CMD_COMMIT : cni_pkg::CMD_UPDATE;
        else if (r < 90) cmd = stepped[k] ? cni_pkg::CMD_REVERT : cni_pkg::CMD_NEW_STEP;
        else cmd = 3'($urandom_range(CMD_RSVD_HI, CMD_RSVD_LO));
        send_req(cmd, k, rand_q(), rand_q(), rand_q());
    endtask

    initial begin
        i_rst_n          = 1'b0;
        req_ch.valid     = 1'b0;
        req_ch.cmd       = cni_pkg::CMD_LOAD;
        req_ch.dof_index = '0;
        req_ch.disp_in   = '0;
        req_ch.vel_in    = '0;
        req_ch.accel_in  = '0;
        cfg_ch.valid     = 1'b0;
        cfg_ch.index     = cni_pkg::CFG_THETA;
        cfg_ch.data      = '0;
        item_count       = 0;
        burst_left       = 0;
        gap_max          = 3;
        cur_theta        = cni_pkg::FX_ONE;
        cur_dt           = '0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset configuration: dt zero
        send_req(cni_pkg::CMD_LOAD, 8'd0, Q_MAX, Q_MIN, '0);
        send_req(cni_pkg::CMD_LOAD, 8'd1, cni_pkg::FX_ONE, cni_pkg::FX_ONE << 1,
                 ~(cni_pkg::FX_ONE * 3) + 64'd1);
        send_req(cni_pkg::CMD_LOAD, 8'd2, Q_MIN, Q_MAX, Q_MAX);
        send_req(cni_pkg::CMD_NEW_STEP, 8'd1, '0, '0, '0);
        send_req(CMD_RSVD_LO, 8'd0, '0, '0, '0);
        send_req(CMD_RSVD_HI, 8'd1, '0, '0, '0);
        send_req(cni_pkg::CMD_UPDATE, 8'd0, Q_MAX, '0, '0);
        drain();
        set_config('0, Q_QUART, cni_pkg::FX_HALF, cni_pkg::FX_ONE, cni_pkg::FX_ONE >> 6);
        send_req(cni_pkg::CMD_NEW_STEP, 8'd1, '0, '0, '0);
        drain();
        set_config(cni_pkg::FX_ONE + cni_pkg::FX_HALF, Q_QUART, cni_pkg::FX_HALF,
                   cni_pkg::FX_ONE, cni_pkg::FX_ONE >> 6);
        send_req(cni_pkg::CMD_NEW_STEP, 8'd1, '0, '0, '0);
        send_req(cni_pkg::CMD_NEW_STEP, 8'd0, '0, '0, '0);
        send_req(cni_pkg::CMD_UPDATE, 8'd1, Q_MAX, '0, '0);
        send_req(cni_pkg::CMD_UPDATE, 8'd1, Q_MIN, '0, '0);
        send_req(cni_pkg::CMD_COMMIT, 8'd1, '0, '0, '0);
        send_req(cni_pkg::CMD_REVERT, 8'd0, '0, '0, '0);
        send_req(cni_pkg::CMD_NEW_STEP, 8'd2, '0, '0, '0);
        send_req(cni_pkg::CMD_COMMIT, 8'd2, '0, '0, '0);
        drain();
        set_config('0, '0, Q_MIN, Q_MIN, Q_MAX);
        send_req(cni_pkg::CMD_COMMIT, 8'd1, '0, '0, '0);
        drain();
        set_config(cni_pkg::FX_ONE, '0, Q_MIN, Q_MIN, Q_MAX);
        send_req(cni_pkg::CMD_NEW_STEP, 8'd1, '0, '0, '0);
        send_req(cni_pkg::CMD_UPDATE, 8'd1, cni_pkg::FX_ONE, '0, '0);
        send_req(cni_pkg::CMD_COMMIT, 8'd1, '0, '0, '0);
        drain();
        set_config(Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX);
        send_req(cni_pkg::CMD_NEW_STEP, 8'd2, '0, '0, '0);
        send_req(cni_pkg::CMD_UPDATE, 8'd2, Q_MIN, '0, '0);
        send_req(cni_pkg::CMD_COMMIT, 8'd2, '0, '0, '0);
        send_req(cni_pkg::CMD_REVERT, 8'd2, '0, '0, '0);
        drain();

        for (int ph = 0; ph < 8; ph++) begin
            set_config(pick_reg(cni_pkg::FX_ONE + {32'd0, $urandom}),
                       pick_reg(64'h2666_6666 + 64'($urandom_range(32'h1000_0000))),
                       pick_reg(cni_pkg::FX_HALF + 64'($urandom_range(32'h2000_0000))),
                       pick_reg(cni_pkg::FX_HALF + 64'($urandom_range(32'h8000_0000))),
                       pick_reg(64'($urandom_range(32'h1000_0000, 1))));
            gap_max = (ph % 3 == 0) ? 0 : $urandom_range(8, 1);
            for (int n = 0; n < 155; n++) random_item();
            drain();
        end

        if (fail_count == 0 && pending == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
